/* src/inductive_line_steering_pd_macros.svh */
// Assertion macros shared by the steering controller modules.
// Each module that uses them has ports named clk and rst.
`ifndef INDUCTIVE_LINE_STEERING_PD_MACROS_SVH
`define INDUCTIVE_LINE_STEERING_PD_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ILSPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ilspd assertion failed");
`define ILSPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ilspd assertion failed");
`else
`define ILSPD_ASSERT_SAME(label, ante, cons)
`define ILSPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/ilspd_pkg.sv */
`timescale 1ns / 1ps
package ilspd_pkg;

  localparam int SAMPLE_BITS   = 8;
  localparam int WINDOW_TAPS   = 5;
  localparam int HIST          = WINDOW_TAPS - 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int SPEED_BITS    = 14;
  localparam int DRIVE_BITS    = 11;
  localparam int ERROR_BITS    = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN_P            = 3'd0,
    REG_GAIN_D            = 3'd1,
    REG_DRIVE_LIMIT       = 3'd2,
    REG_BASE_SPEED        = 3'd3,
    REG_DRIVE_THRESHOLD   = 3'd4,
    REG_RIGHT_LEVEL_LIMIT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_d;
    logic [9:0]         drive_limit;
    logic [11:0]        base_speed;
    logic [9:0]         drive_threshold;
    logic [7:0]         right_level_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:            16'sd0,
    gain_d:            16'sd0,
    drive_limit:       10'd200,
    base_speed:        12'd1700,
    drive_threshold:   10'd50,
    right_level_limit: 8'd210
  };

  typedef struct packed {
    logic load_in;
    logic filt;
    logic div_start;
    logic div_step;
    logic mul_p;
    logic mul_d;
    logic clamp;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/ilspd_in_if.sv */
`timescale 1ns / 1ps
interface ilspd_in_if import ilspd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] mid_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output mid_sample,
                  output right_sample, input ready);
  modport sink (input valid, input left_sample, input mid_sample,
                input right_sample, output ready);
endinterface

/* src/ilspd_out_if.sv */
`timescale 1ns / 1ps
interface ilspd_out_if import ilspd_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [SPEED_BITS-1:0] left_motor_speed;
  logic signed [SPEED_BITS-1:0] right_motor_speed;
  logic signed [DRIVE_BITS-1:0] steer_drive;
  logic signed [ERROR_BITS-1:0] offset_error;
  logic [SAMPLE_BITS-1:0]       left_level;
  logic [SAMPLE_BITS-1:0]       mid_level;
  logic [SAMPLE_BITS-1:0]       right_level;

  modport source (output valid, output left_motor_speed, output right_motor_speed,
                  output steer_drive, output offset_error, output left_level,
                  output mid_level, output right_level, input ready);
  modport sink (input valid, input left_motor_speed, input right_motor_speed,
                input steer_drive, input offset_error, input left_level,
                input mid_level, input right_level, output ready);
endinterface

/* src/ilspd_cfg_if.sv */
`timescale 1ns / 1ps
interface ilspd_cfg_if import ilspd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/ilspd_cfg_regs.sv */
`timescale 1ns / 1ps
module ilspd_cfg_regs import ilspd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ilspd_cfg_if.sink cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_P:            regs.gain_p <= cfg.data;
        REG_GAIN_D:            regs.gain_d <= cfg.data;
        REG_DRIVE_LIMIT:       regs.drive_limit <= cfg.data[9:0];
        REG_BASE_SPEED:        regs.base_speed <= cfg.data[11:0];
        REG_DRIVE_THRESHOLD:   regs.drive_threshold <= cfg.data[9:0];
        REG_RIGHT_LEVEL_LIMIT: regs.right_level_limit <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/ilspd_ctrl.sv */
`timescale 1ns / 1ps
`include "inductive_line_steering_pd_macros.svh"
module ilspd_ctrl import ilspd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FILT  = 8'b0000_0010,
    S_DIVI  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_MULP  = 8'b0001_0000,
    S_MULD  = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_MIX   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_FILT;
      S_FILT:  state_next = S_DIVI;
      S_DIVI:  state_next = S_DIV;
      S_DIV:   if (stat.div_done) state_next = S_MULP;
      S_MULP:  state_next = S_MULD;
      S_MULD:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_MIX;
      S_MIX:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.filt      = (state == S_FILT);
    cmd.div_start = (state == S_DIVI);
    cmd.div_step  = (state == S_DIV);
    cmd.mul_p     = (state == S_MULP);
    cmd.mul_d     = (state == S_MULD);
    cmd.clamp     = (state == S_CLAMP);
    cmd.load_out  = (state == S_MIX) && stat.out_free;
  end

  `ILSPD_ASSERT_NEXT(a_accept_to_filter, in_valid && in_ready, state == S_FILT)
  `ILSPD_ASSERT_NEXT(a_div_exit, state == S_DIV && stat.div_done, state == S_MULP)
  `ILSPD_ASSERT_SAME(a_load_needs_room, cmd.load_out, stat.out_free)

endmodule

/* src/ilspd_datapath.sv */
`timescale 1ns / 1ps
`include "inductive_line_steering_pd_macros.svh"
module ilspd_datapath import ilspd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] left_sample,
  input  logic [SAMPLE_BITS-1:0] mid_sample,
  input  logic [SAMPLE_BITS-1:0] right_sample,
  input  cfg_t                   cfg,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  ilspd_out_if.source            speeds
);

  localparam int ACC_BITS   = SAMPLE_BITS + 5;
  localparam int QTR_BITS   = ACC_BITS - 2;
  localparam int PROD5_BITS = QTR_BITS + 16;
  localparam int REM_BITS   = 15;
  localparam int QUOT_BITS  = 7;
  localparam int CNT_BITS   = 3;
  localparam int SUM_BITS   = 26;
  localparam int DRAW_BITS  = SUM_BITS - 8;
  localparam int MIX_BITS   = 15;
  localparam logic [15:0]            RECIP5    = 16'd13108;
  localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [6:0]             PERCENT   = 7'd100;

  // Filtered level: weights 1,1,2,2,16 over 20. The divide by 20 is a shift by
  // two and a multiply by the reciprocal of five, exact over the whole range.
  function automatic logic [SAMPLE_BITS-1:0] smooth(
    input logic [SAMPLE_BITS-1:0] w0,
    input logic [SAMPLE_BITS-1:0] w1,
    input logic [SAMPLE_BITS-1:0] w2,
    input logic [SAMPLE_BITS-1:0] w3,
    input logic [SAMPLE_BITS-1:0] fresh
  );
    logic [ACC_BITS-1:0]   acc;
    logic [PROD5_BITS-1:0] prod;
    logic [QTR_BITS-1:0]   q;
    acc = ACC_BITS'(w0) + ACC_BITS'(w1) + (ACC_BITS'(w2) << 1) + (ACC_BITS'(w3) << 1)
        + (ACC_BITS'(fresh) << 4);
    prod = PROD5_BITS'(acc[ACC_BITS-1:2]) * PROD5_BITS'(RECIP5);
    q = prod[PROD5_BITS-1:16];
    if (q > QTR_BITS'(LEVEL_MAX)) begin
      smooth = LEVEL_MAX;
    end else begin
      smooth = q[SAMPLE_BITS-1:0];
    end
  endfunction

  logic [SAMPLE_BITS-1:0] ls, ms, rs;
  logic [SAMPLE_BITS-1:0] lwin [HIST];
  logic [SAMPLE_BITS-1:0] mwin [HIST];
  logic [SAMPLE_BITS-1:0] rwin [HIST];
  logic [SAMPLE_BITS-1:0] lvl_l, lvl_m, lvl_r;

  logic [REM_BITS-1:0]    rem;
  logic [SAMPLE_BITS:0]   den;
  logic [QUOT_BITS-1:0]   quot;
  logic [CNT_BITS-1:0]    cnt;
  logic                   neg;
  logic                   den_zero;
  logic [REM_BITS-1:0]    shifted;
  logic [SAMPLE_BITS-1:0] diff_mag;

  logic signed [ERROR_BITS-1:0] e_comb;
  logic signed [ERROR_BITS-1:0] err;
  logic signed [ERROR_BITS-1:0] prev_err;
  logic signed [15:0]           mul_a;
  logic signed [ERROR_BITS:0]   mul_b;
  logic signed [SUM_BITS-2:0]   product;
  logic signed [SUM_BITS-1:0]   acc;
  logic signed [SUM_BITS-1:0]   acc_adj;
  logic signed [DRAW_BITS-1:0]  d_raw;
  logic signed [DRAW_BITS-1:0]  lim_s;
  logic signed [DRAW_BITS-1:0]  neg_lim;
  logic signed [DRIVE_BITS-1:0] drive;
  logic signed [DRIVE_BITS-1:0] lim_d;

  logic signed [MIX_BITS-1:0] b15, d15, t15, seven, half7, sl, sr;

  // Long division of |L-R|*100 by L+R, one quotient bit per cycle.
  assign shifted       = REM_BITS'(den) << cnt;
  assign diff_mag      = (lvl_l >= lvl_r) ? (lvl_l - lvl_r) : (lvl_r - lvl_l);
  assign stat.div_done = (cnt == '0);
  assign stat.out_free = !speeds.valid || speeds.ready;

  always_comb begin
    if (den_zero) begin
      e_comb = '0;
    end else if (neg) begin
      e_comb = -$signed({1'b0, quot});
    end else begin
      e_comb = $signed({1'b0, quot});
    end
  end

  // One shared multiplier: proportional term first, then derivative term.
  always_comb begin
    mul_a   = cmd.mul_d ? cfg.gain_d : cfg.gain_p;
    mul_b   = cmd.mul_d ? ({err[ERROR_BITS-1], err} - {prev_err[ERROR_BITS-1], prev_err})
                        : {e_comb[ERROR_BITS-1], e_comb};
    product = (SUM_BITS-1)'(mul_a) * (SUM_BITS-1)'(mul_b);
  end

  always_comb begin
    acc_adj = acc[SUM_BITS-1] ? (acc + SUM_BITS'(255)) : acc;
    d_raw   = acc_adj[SUM_BITS-1:8];
    lim_s   = {{(DRAW_BITS-10){1'b0}}, cfg.drive_limit};
    neg_lim = -lim_s;
    lim_d   = {1'b0, cfg.drive_limit};
  end

  always_comb begin
    b15   = {3'b0, cfg.base_speed};
    d15   = {{(MIX_BITS-DRIVE_BITS){drive[DRIVE_BITS-1]}}, drive};
    t15   = {5'b0, cfg.drive_threshold};
    seven = (d15 <<< 3) - d15;
    half7 = seven[MIX_BITS-1] ? ((seven + 15'sd1) >>> 1) : (seven >>> 1);
    if (lvl_l < lvl_r && lvl_r <= cfg.right_level_limit && d15 > -t15) begin
      sl = b15 - d15;
      sr = b15 + (d15 <<< 1);
    end else if (lvl_l > lvl_r && d15 < t15) begin
      sl = b15 - (d15 <<< 1);
      sr = b15 + d15;
    end else if (lvl_l > lvl_r && d15 > t15) begin
      sl = b15 - half7;
      sr = b15 + d15;
    end else if (lvl_l < lvl_r && d15 < -t15) begin
      sl = b15 - d15;
      sr = b15 + half7;
    end else begin
      sl = b15;
      sr = b15;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ls <= left_sample;
      ms <= mid_sample;
      rs <= right_sample;
    end
    if (cmd.filt) begin
      lvl_l <= smooth(lwin[0], lwin[1], lwin[2], lwin[3], ls);
      lvl_m <= smooth(mwin[0], mwin[1], mwin[2], mwin[3], ms);
      lvl_r <= smooth(rwin[0], rwin[1], rwin[2], rwin[3], rs);
    end
    if (cmd.div_start) begin
      rem      <= REM_BITS'(diff_mag) * REM_BITS'(PERCENT);
      den      <= {1'b0, lvl_l} + {1'b0, lvl_r};
      neg      <= (lvl_l < lvl_r);
      den_zero <= (lvl_l == '0) && (lvl_r == '0);
      quot     <= '0;
      cnt      <= CNT_BITS'(QUOT_BITS - 1);
    end
    if (cmd.div_step) begin
      if (rem >= shifted) begin
        rem       <= rem - shifted;
        quot[cnt] <= 1'b1;
      end
      cnt <= cnt - 1'b1;
    end
    if (cmd.mul_p) begin
      err <= e_comb;
      acc <= {product[SUM_BITS-2], product};
    end
    if (cmd.mul_d) begin
      acc <= acc + {product[SUM_BITS-2], product};
    end
    if (cmd.clamp) begin
      if (d_raw > lim_s) begin
        drive <= lim_d;
      end else if (d_raw < neg_lim) begin
        drive <= -lim_d;
      end else begin
        drive <= d_raw[DRIVE_BITS-1:0];
      end
    end
    if (cmd.load_out) begin
      speeds.left_motor_speed  <= sl[SPEED_BITS-1:0];
      speeds.right_motor_speed <= sr[SPEED_BITS-1:0];
      speeds.steer_drive       <= drive;
      speeds.offset_error      <= err;
      speeds.left_level        <= lvl_l;
      speeds.mid_level         <= lvl_m;
      speeds.right_level       <= lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST; i++) begin
        lwin[i] <= '0;
        mwin[i] <= '0;
        rwin[i] <= '0;
      end
      prev_err     <= '0;
      speeds.valid <= 1'b0;
    end else begin
      if (cmd.filt) begin
        for (int i = 0; i < HIST - 1; i++) begin
          lwin[i] <= lwin[i+1];
          mwin[i] <= mwin[i+1];
          rwin[i] <= rwin[i+1];
        end
        lwin[HIST-1] <= ls;
        mwin[HIST-1] <= ms;
        rwin[HIST-1] <= rs;
      end
      if (cmd.mul_d) begin
        prev_err <= err;
      end
      if (cmd.load_out) begin
        speeds.valid <= 1'b1;
      end else if (speeds.ready) begin
        speeds.valid <= 1'b0;
      end
    end
  end

  `ILSPD_ASSERT_SAME(a_drive_in_limit, cmd.load_out, drive <= lim_d && drive >= -lim_d)
  `ILSPD_ASSERT_SAME(a_error_range, cmd.load_out, err <= 8'sd100 && err >= -8'sd100)
  `ILSPD_ASSERT_NEXT(a_out_loaded, cmd.load_out, speeds.valid)

endmodule

/* src/inductive_line_steering_pd.sv */
`timescale 1ns / 1ps
// Steering controller for an inductive line follower.
// The samples channel takes one word of left, middle and right sensor readings.
// Each word yields exactly one word on the speeds channel: two motor speeds, the
// clamped PD drive, the offset error in percent and the three filtered levels.
// The cfg channel writes the gain, limit, speed and threshold registers by index;
// it is always ready and should be written only while no word is in flight.
// After a sample word is accepted, the controller steps through the filter,
// divider setup, the bit-serial divider that forms the percent error, two passes
// of the shared PD multiplier, clamp and mix; a new sample word is accepted only
// once this sequence has returned to idle.
// The result sits in an output register, so the next sample word is taken while
// the previous result still waits; if the receiver keeps stalling, the block
// holds in the mix step until the output register frees up.
// Reset clears the filter windows and the previous error, drops the output valid
// and loads every configuration register with its default value.
module inductive_line_steering_pd import ilspd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ilspd_in_if.sink    samples,
  ilspd_out_if.source speeds,
  ilspd_cfg_if.sink   cfg
);

  cfg_t     regs;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign samples.ready = in_ready;

  ilspd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ilspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilspd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .left_sample  (samples.left_sample),
    .mid_sample   (samples.mid_sample),
    .right_sample (samples.right_sample),
    .cfg          (regs),
    .cmd          (cmd),
    .stat         (stat),
    .speeds       (speeds)
  );

endmodule

/* tb/sv/ilspd_checker.sv */
`timescale 1ns / 1ps
module ilspd_checker import ilspd_pkg::*; (
  input  logic clk,
  input  logic rst,
  ilspd_in_if  samples,
  ilspd_out_if speeds,
  ilspd_cfg_if cfg,
  output int   errors,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
    logic signed [DRIVE_BITS-1:0] drive;
    logic signed [ERROR_BITS-1:0] error;
    logic [SAMPLE_BITS-1:0]       left_lvl;
    logic [SAMPLE_BITS-1:0]       mid_lvl;
    logic [SAMPLE_BITS-1:0]       right_lvl;
  } speeds_t;

  localparam int LEVEL_MAX = (1 << SAMPLE_BITS) - 1;

  cfg_t                              shadow;
  logic [HIST-1:0][SAMPLE_BITS-1:0] left_win;
  logic [HIST-1:0][SAMPLE_BITS-1:0] mid_win;
  logic [HIST-1:0][SAMPLE_BITS-1:0] right_win;
  longint                            last_error;
  speeds_t                           speeds_q[$];
  int                                fail_count;
  int                                seen_count;

  // Index 0 holds the oldest sample, index HIST-1 the newest.
  function automatic int filter_level(input logic [HIST-1:0][SAMPLE_BITS-1:0] win,
                                      input logic [SAMPLE_BITS-1:0] fresh);
    int acc;
    acc = int'(win[0]) + int'(win[1]) + 2 * int'(win[2]) + 2 * int'(win[3]) +
          16 * int'(fresh);
    acc = acc / 20;
    if (acc > LEVEL_MAX) acc = LEVEL_MAX;
    return acc;
  endfunction

  function automatic speeds_t predict_speeds(input logic [SAMPLE_BITS-1:0] ls,
                                             input logic [SAMPLE_BITS-1:0] ms,
                                             input logic [SAMPLE_BITS-1:0] rs);
    speeds_t res;
    longint l, m, r, e, sum, d, lim, b, t, rl, sl, sr;
    l = filter_level(left_win, ls);
    m = filter_level(mid_win, ms);
    r = filter_level(right_win, rs);
    left_win = {ls, left_win[HIST-1:1]};
    mid_win = {ms, mid_win[HIST-1:1]};
    right_win = {rs, right_win[HIST-1:1]};

    if (l + r == 0) e = 0;
    else e = ((l - r) * 100) / (l + r);

    sum = longint'($signed(shadow.gain_p)) * e +
          longint'($signed(shadow.gain_d)) * (e - last_error);
    d = sum / 256;
    lim = longint'(shadow.drive_limit);
    if (d > lim) d = lim;
    else if (d < -lim) d = -lim;
    last_error = e;

    b = longint'(shadow.base_speed);
    t = longint'(shadow.drive_threshold);
    rl = longint'(shadow.right_level_limit);
    if (l < r && r <= rl && d > -t) begin
      sl = b - d;
      sr = b + 2 * d;
    end else if (l > r && d < t) begin
      sl = b - 2 * d;
      sr = b + d;
    end else if (l > r && d > t) begin
      sl = b - (7 * d) / 2;
      sr = b + d;
    end else if (l < r && d < -t) begin
      sl = b - d;
      sr = b + (7 * d) / 2;
    end else begin
      sl = b;
      sr = b;
    end

    res.left_speed = sl[SPEED_BITS-1:0];
    res.right_speed = sr[SPEED_BITS-1:0];
    res.drive = d[DRIVE_BITS-1:0];
    res.error = e[ERROR_BITS-1:0];
    res.left_lvl = l[SAMPLE_BITS-1:0];
    res.mid_lvl = m[SAMPLE_BITS-1:0];
    res.right_lvl = r[SAMPLE_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    speeds_t want;
    speeds_t got;
    if (rst) begin
      shadow = CFG_RESET;
      left_win = '0;
      mid_win = '0;
      right_win = '0;
      last_error = 0;
      speeds_q.delete();
      fail_count = 0;
      seen_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_GAIN_P:            shadow.gain_p = cfg.data;
          REG_GAIN_D:            shadow.gain_d = cfg.data;
          REG_DRIVE_LIMIT:       shadow.drive_limit = cfg.data[9:0];
          REG_BASE_SPEED:        shadow.base_speed = cfg.data[11:0];
          REG_DRIVE_THRESHOLD:   shadow.drive_threshold = cfg.data[9:0];
          REG_RIGHT_LEVEL_LIMIT: shadow.right_level_limit = cfg.data[7:0];
          default: ;
        endcase
      end

      if (speeds.valid && speeds.ready) begin
        seen_count++;
        got.left_speed = speeds.left_motor_speed;
        got.right_speed = speeds.right_motor_speed;
        got.drive = speeds.steer_drive;
        got.error = speeds.offset_error;
        got.left_lvl = speeds.left_level;
        got.mid_lvl = speeds.mid_level;
        got.right_lvl = speeds.right_level;
        if (speeds_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Speeds word %0d arrived with no sample word pending.", seen_count);
        end else begin
          want = speeds_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Speeds word %0d mismatch:", seen_count);
              $display("  expected speeds %0d/%0d drive %0d error %0d levels %0d/%0d/%0d",
                       want.left_speed, want.right_speed, want.drive,
                       want.error, want.left_lvl, want.mid_lvl, want.right_lvl);
              $display("  got      speeds %0d/%0d drive %0d error %0d levels %0d/%0d/%0d",
                       got.left_speed, got.right_speed, got.drive, got.error,
                       got.left_lvl, got.mid_lvl, got.right_lvl);
            end
          end
        end
      end

      if (samples.valid && samples.ready)
        speeds_q.push_back(predict_speeds(samples.left_sample, samples.mid_sample,
                                          samples.right_sample));
    end
    errors <= fail_count;
    pending <= speeds_q.size();
    results_seen <= seen_count;
  end

endmodule

/* tb/sv/tb_inductive_line_steering_pd.sv */
`timescale 1ns / 1ps
module tb_inductive_line_steering_pd;
  import ilspd_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 30;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ilspd_in_if  samples();
  ilspd_out_if speeds();
  ilspd_cfg_if cfg();

  int  errors;
  int  pending;
  int  results_seen;
  int  words_sent;
  int  settings_applied;
  bit  quiet;
  bit  hold_request;
  bit  hold_done;
  logic [SAMPLE_BITS-1:0] track_l;
  logic [SAMPLE_BITS-1:0] track_m;
  logic [SAMPLE_BITS-1:0] track_r;

  always #10 clk = ~clk;

  inductive_line_steering_pd i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .speeds  (speeds),
    .cfg     (cfg)
  );

  ilspd_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .speeds       (speeds),
    .cfg          (cfg),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  task automatic send_word(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] m,
                           input logic [SAMPLE_BITS-1:0] r);
    while (!quiet && $urandom_range(99) < 38) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.left_sample <= l;
    samples.mid_sample <= m;
    samples.right_sample <= r;
    do @(posedge clk); while (!samples.ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Bits above each register's width carry junk that the block must drop.
  task automatic apply_setting(input logic [15:0] gp, input logic [15:0] gd,
                               input logic [9:0] lim, input logic [11:0] base,
                               input logic [9:0] thr, input logic [7:0] rll);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_LIMIT, {6'($urandom), lim});
    write_reg(REG_BASE_SPEED, {4'($urandom), base});
    write_reg(REG_DRIVE_THRESHOLD, {6'($urandom), thr});
    write_reg(REG_RIGHT_LEVEL_LIMIT, {8'($urandom), rll});
    cfg.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_drained();
    samples.valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    int g;
    g = int'($urandom_range(0, 3072)) - 1536;
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'(g);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] wander(input logic [SAMPLE_BITS-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(0, 32)) - 16;
    if (n < 0) n = 0;
    if (n > (1 << SAMPLE_BITS) - 1) n = (1 << SAMPLE_BITS) - 1;
    return SAMPLE_BITS'(n);
  endfunction

  // Mostly a slowly drifting line, with noise, tiny levels and rail values mixed in.
  task automatic send_random_word();
    int pick;
    logic [SAMPLE_BITS-1:0] l, m, r;
    pick = $urandom_range(99);
    if (pick < 55) begin
      track_l = wander(track_l);
      track_m = wander(track_m);
      track_r = wander(track_r);
      l = track_l;
      m = track_m;
      r = track_r;
    end else if (pick < 80) begin
      l = SAMPLE_BITS'($urandom);
      m = SAMPLE_BITS'($urandom);
      r = SAMPLE_BITS'($urandom);
    end else if (pick < 90) begin
      l = SAMPLE_BITS'($urandom_range(0, 3));
      m = SAMPLE_BITS'($urandom_range(0, 3));
      r = SAMPLE_BITS'($urandom_range(0, 3));
    end else begin
      l = $urandom_range(0, 1) ? '1 : '0;
      m = $urandom_range(0, 1) ? '1 : '0;
      r = $urandom_range(0, 1) ? '1 : '0;
    end
    send_word(l, m, r);
  endtask

  initial begin
    speeds.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          speeds.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        speeds.ready <= quiet || ($urandom_range(99) >= 38);
        @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timed out waiting for the block.");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    samples.valid <= 1'b0;
    samples.left_sample <= '0;
    samples.mid_sample <= '0;
    samples.right_sample <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    track_l = 8'd128;
    track_m = 8'd200;
    track_r = 8'd128;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: zero gains, so only the filters and the error move.
    send_word(8'd0, 8'd0, 8'd0);
    send_word(8'd255, 8'd255, 8'd255);
    send_word(8'd255, 8'd255, 8'd255);
    send_word(8'd255, 8'd255, 8'd255);
    send_word(8'd255, 8'd0, 8'd0);
    send_word(8'd0, 8'd128, 8'd255);

    wait_drained();
    apply_setting(16'sh0400, 16'sh0200, 10'd200, 12'd1700, 10'd50, 8'd210);
    send_word(8'd0, 8'd0, 8'd0);
    send_word(8'd255, 8'd0, 8'd0);
    send_word(8'd255, 8'd0, 8'd0);
    send_word(8'd0, 8'd0, 8'd100);
    send_word(8'd0, 8'd0, 8'd100);
    send_word(8'd0, 8'd0, 8'd255);
    send_word(8'd0, 8'd0, 8'd255);
    send_word(8'd0, 8'd0, 8'd255);
    send_word(8'd120, 8'd90, 8'd118);
    send_word(8'd120, 8'd90, 8'd122);
    send_word(8'd100, 8'd255, 8'd100);
    send_word(8'd1, 8'd1, 8'd0);
    send_word(8'd170, 8'd85, 8'd85);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: apply_setting(16'sh7fff, 16'sh7fff, 10'd1023, 12'd4095, 10'd1023, 8'd255);
        1: apply_setting(16'sh8000, 16'sh8000, 10'd0, 12'd0, 10'd0, 8'd0);
        2: apply_setting(16'sh7fff, 16'sh8000, 10'd1023, 12'd4095, 10'd0, 8'd255);
        default: begin
          write_reg(REG_SPARE_LO, 16'($urandom));
          write_reg(REG_SPARE_HI, 16'($urandom));
          apply_setting(pick_gain(), pick_gain(), 10'($urandom_range(0, 1023)),
                        12'($urandom), 10'($urandom_range(0, 200)), 8'($urandom));
        end
      endcase
      quiet = (ph == 4);
      if (ph == 5) hold_request = 1'b1;
      repeat (WORDS_PER_PHASE) send_random_word();
    end

    samples.valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d speeds words for %0d sample words under %0d register settings,",
             results_seen, words_sent, settings_applied);
    $display("with random idling on both sides, a quiet stretch and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
